// ===== src/ssrb_pkg.sv =====
// Shared types, codes and constants for the stereo sample ring buffer.
// No dependencies; imported by every module of the block.
package ssrb_pkg;

  // Default ring depth in frames (top-level parameter default).
  localparam int RING_FRAMES_DEF = 32768;

  // Longest read block and fill level reporting ceiling.
  localparam logic [12:0] BLOCK_MAX = 13'd4096;
  localparam logic [14:0] FILL_SAT  = 15'h7FFF;

  // Sample clamp bounds for 32-bit input formats.
  localparam logic signed [31:0] CLAMP_HI = 32'sd32766;
  localparam logic signed [31:0] CLAMP_LO = -32'sd32766;

  // Configuration port.
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 15;
  localparam logic [CFG_IW-1:0] CFG_INPUT_FORMAT   = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_OVERFLOW_LIMIT = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_BLOCK_FRAMES   = 2'd2;

  // Input format codes (unused code falls back to stereo 32-bit).
  localparam logic [1:0] FMT_STEREO32 = 2'd0;
  localparam logic [1:0] FMT_STEREO16 = 2'd1;
  localparam logic [1:0] FMT_MONO32   = 2'd2;

  // Register reset values.
  localparam logic [1:0]  FMT_RESET   = FMT_STEREO32;
  localparam logic [14:0] LIMIT_RESET = 15'd20480;
  localparam logic [12:0] BLOCK_RESET = 13'd512;

  // Request and result codes.
  localparam logic MODE_PUSH   = 1'b0;
  localparam logic MODE_POP    = 1'b1;
  localparam logic KIND_FRAME  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] sample_right;
    logic signed [31:0] sample_left;
    logic               batch_last;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] out_right;
    logic signed [15:0] out_left;
    logic               underrun;
    logic               batch_dropped;
    logic [14:0]        fill_level;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ
  } ctrl_state_t;

  // Controller -> datapath
  typedef struct packed {
    logic capture;
    logic push;
    logic pop;
    logic emit;
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic is_pop;
    logic is_last;
    logic out_free;
  } dp_status_t;

  function automatic logic [15:0] clamp16(input logic signed [31:0] s);
    logic [15:0] res;
    if (s < CLAMP_LO) begin
      res = CLAMP_LO[15:0];
    end else if (s > CLAMP_HI) begin
      res = CLAMP_HI[15:0];
    end else begin
      res = s[15:0];
    end
    return res;
  endfunction

endpackage

// ===== src/ssrb_ctrl.sv =====
// Sequencing FSM for the stereo sample ring buffer.
// Depends on ssrb_pkg; drives ssrb_datapath through dp_cmd_t.
module ssrb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ssrb_pkg::dp_status_t status,
  output ssrb_pkg::dp_cmd_t    cmd
);
  import ssrb_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (status.is_pop) begin
          state_nxt = ST_READ;
        end else if (!status.is_last || status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_EXEC: begin
        if (status.is_pop) begin
          cmd.pop = 1'b1;
        end else begin
          // a batch end needs the result slot before any state moves
          cmd.push = !status.is_last || status.out_free;
        end
      end
      ST_READ: begin
        cmd.emit = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== src/ssrb_datapath.sv =====
// Ring memory, pointers, config registers and result register.
// Depends on ssrb_pkg; sequenced by ssrb_ctrl.
module ssrb_datapath #(
  parameter int RING_FRAMES = ssrb_pkg::RING_FRAMES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ssrb_pkg::in_item_t                  in_data,
  input  logic                                cfg_valid,
  input  logic [ssrb_pkg::CFG_IW-1:0]         cfg_index,
  input  logic [ssrb_pkg::CFG_DW-1:0]         cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ssrb_pkg::out_item_t                 out_data,
  input  ssrb_pkg::dp_cmd_t                   cmd,
  output ssrb_pkg::dp_status_t                status
);
  import ssrb_pkg::*;

  localparam int AW = $clog2(RING_FRAMES);
  localparam int FW = (AW > 15) ? AW : 15;   // fill vs limit / saturation
  localparam int CW = (AW > 13) ? AW : 13;   // fill vs block size
  localparam int SW = CW + 1;                // pointer sums before wrap
  localparam logic [AW-1:0] LAST_IDX = AW'(RING_FRAMES - 1);

  function automatic logic [AW-1:0] ring_fill(input logic [AW-1:0] c,
                                              input logic [AW-1:0] r);
    logic [AW:0] d;
    if (c >= r) begin
      d = {1'b0, c} - {1'b0, r};
    end else begin
      d = {1'b0, c} + (AW+1)'(RING_FRAMES) - {1'b0, r};
    end
    return d[AW-1:0];
  endfunction

  function automatic logic [14:0] sat_fill(input logic [AW-1:0] f);
    logic [FW-1:0] e;
    e = FW'(f);
    return (e > FW'(FILL_SAT)) ? FILL_SAT : e[14:0];
  endfunction

  function automatic logic [AW-1:0] wrap_sum(input logic [SW-1:0] s);
    logic [SW-1:0] w;
    w = (s >= SW'(RING_FRAMES)) ? (s - SW'(RING_FRAMES)) : s;
    return w[AW-1:0];
  endfunction

  // storage
  logic [31:0]   ring_mem [RING_FRAMES];
  logic [31:0]   mem_q_r;
  logic          rd_ok_r;
  in_item_t      item_r;
  out_item_t     out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [1:0]    fmt_r;
  logic [14:0]   limit_r;
  logic [12:0]   bframes_r;

  logic [AW-1:0] cwp_r, cwp_nxt;
  logic [AW-1:0] pwp_r, pwp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [11:0]   boff_r, boff_nxt;
  logic          playing_r, playing_nxt;
  // written mark: pushes fill the ring from index 0 upward, so every index
  // at or above the mark has not been written since reset and reads as zero
  logic [AW:0]   hwm_r, hwm_nxt;

  logic [AW-1:0] fill_now;
  logic [15:0]   smp_r, smp_l;
  logic [AW-1:0] pwp_inc;
  logic          dropped;
  logic [12:0]   bf_eff;
  logic          play;
  logic [AW-1:0] rd_addr;
  logic          rd_hit;
  logic [12:0]   boff_inc;
  logic          load_out;

  assign fill_now = ring_fill(cwp_r, rp_r);

  assign status.is_pop   = (item_r.mode == MODE_POP);
  assign status.is_last  = item_r.batch_last;
  assign status.out_free = !out_valid_r || out_ready;

  // push sample formatting
  always_comb begin
    case (fmt_r)
      FMT_STEREO16: begin
        smp_r = item_r.sample_right[15:0];
        smp_l = item_r.sample_left[15:0];
      end
      FMT_MONO32: begin
        smp_r = clamp16(item_r.sample_right);
        smp_l = smp_r;
      end
      default: begin
        smp_r = clamp16(item_r.sample_right);
        smp_l = clamp16(item_r.sample_left);
      end
    endcase
  end

  always_comb begin
    if (bframes_r == 13'd0) begin
      bf_eff = 13'd1;
    end else if (bframes_r > BLOCK_MAX) begin
      bf_eff = BLOCK_MAX;
    end else begin
      bf_eff = bframes_r;
    end
  end

  assign pwp_inc  = (pwp_r == LAST_IDX) ? '0 : pwp_r + AW'(1);
  assign dropped  = !(FW'(fill_now) < FW'(limit_r));
  assign play     = (boff_r == 12'd0) ? (CW'(fill_now) >= CW'(bf_eff)) : playing_r;
  assign rd_addr  = wrap_sum(SW'(rp_r) + SW'(boff_r));
  assign rd_hit   = ({1'b0, rd_addr} < hwm_r);
  assign boff_inc = {1'b0, boff_r} + 13'd1;

  // pointer and block state
  always_comb begin
    cwp_nxt     = cwp_r;
    pwp_nxt     = pwp_r;
    rp_nxt      = rp_r;
    boff_nxt    = boff_r;
    playing_nxt = playing_r;
    hwm_nxt     = hwm_r;
    if (cmd.push) begin
      pwp_nxt = pwp_inc;
      if ({1'b0, pwp_r} == hwm_r) hwm_nxt = hwm_r + (AW+1)'(1);
      if (item_r.batch_last) begin
        if (dropped) begin
          pwp_nxt = cwp_r;
        end else begin
          cwp_nxt = pwp_inc;
        end
      end
    end
    if (cmd.pop) begin
      playing_nxt = play;
      if (boff_inc >= bf_eff) begin
        boff_nxt = 12'd0;
        if (play) rp_nxt = wrap_sum(SW'(rp_r) + SW'(bf_eff));
      end else begin
        boff_nxt = boff_inc[11:0];
      end
    end
  end

  // result register
  always_comb begin
    out_nxt  = out_r;
    load_out = 1'b0;
    if (cmd.push && item_r.batch_last) begin
      load_out              = 1'b1;
      out_nxt.kind          = KIND_STATUS;
      out_nxt.out_right     = '0;
      out_nxt.out_left      = '0;
      out_nxt.underrun      = 1'b0;
      out_nxt.batch_dropped = dropped;
      out_nxt.fill_level    = sat_fill(ring_fill(cwp_nxt, rp_r));
    end else if (cmd.emit) begin
      load_out              = 1'b1;
      out_nxt.kind          = KIND_FRAME;
      out_nxt.out_right     = (playing_r && rd_ok_r) ? mem_q_r[15:0] : 16'd0;
      out_nxt.out_left      = (playing_r && rd_ok_r) ? mem_q_r[31:16] : 16'd0;
      out_nxt.underrun      = !playing_r;
      out_nxt.batch_dropped = 1'b0;
      out_nxt.fill_level    = sat_fill(fill_now);
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) ring_mem[pwp_r] <= {smp_l, smp_r};
    if (cmd.pop)  mem_q_r <= ring_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_data;
    if (cmd.pop) rd_ok_r <= rd_hit;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r       <= FMT_RESET;
      limit_r     <= LIMIT_RESET;
      bframes_r   <= BLOCK_RESET;
      cwp_r       <= '0;
      pwp_r       <= '0;
      rp_r        <= '0;
      boff_r      <= '0;
      playing_r   <= 1'b0;
      hwm_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cwp_r       <= cwp_nxt;
      pwp_r       <= pwp_nxt;
      rp_r        <= rp_nxt;
      boff_r      <= boff_nxt;
      playing_r   <= playing_nxt;
      hwm_r       <= hwm_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_INPUT_FORMAT:   fmt_r     <= cfg_data[1:0];
          CFG_OVERFLOW_LIMIT: limit_r   <= cfg_data[14:0];
          CFG_BLOCK_FRAMES:   bframes_r <= cfg_data[12:0];
          default: ;
        endcase
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== src/stereo_sample_ring_buffer_top.sv =====
// Order: a push is captured into the item register and then written to the ring in EXEC,
// where a batch end also loads its status into the result register; a pop is captured,
// its ring read is registered in EXEC, and the frame enters the result register in READ.
// Requests are taken one at a time, only in IDLE. A stalled result holds only requests
// that need the result slot. Reset: synchronous, active low; clears pointers, block state,
// written mark, config to defaults; no ring sweep, requests are taken the cycle after reset.
module stereo_sample_ring_buffer_top #(
  parameter int RING_FRAMES = ssrb_pkg::RING_FRAMES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  ssrb_pkg::in_item_t          in_data,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output ssrb_pkg::out_item_t         out_data,
  // configuration writes
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ssrb_pkg::CFG_IW-1:0] cfg_index,
  input  logic [ssrb_pkg::CFG_DW-1:0] cfg_data
);
  import ssrb_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Config registers are plain flops; a write always lands.
  assign cfg_ready = 1'b1;

  // Controller: IDLE takes a request into the item register, EXEC does the
  // push (memory write, pointer/commit update) or issues the pop's ring read
  // and block bookkeeping, READ formats the popped frame once the result
  // register is free. A batch end waits in EXEC until the result slot frees,
  // so nothing is committed before its status can be posted.
  ssrb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: ring memory (left in upper half, right in lower), committed /
  // pending write pointers, read pointer, block offset and play flag.
  // A block size raised mid-block can read past what was ever pushed; a
  // written mark (the ring fills upward from index 0) makes those reads zero,
  // so the ring needs no reset sweep.
  ssrb_datapath #(
    .RING_FRAMES (RING_FRAMES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ===== src/ssrb_checker.sv =====
// Port-level checks for the stereo sample ring buffer, bound to the top level.
// Depends on ssrb_pkg and stereo_sample_ring_buffer_top.
module ssrb_port_props (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input ssrb_pkg::out_item_t out_data
);
  import ssrb_pkg::*;

  // result must hold while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // one request at a time: no request taken right after another
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one in flight");

  // nothing pending after reset
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a new result only appears while a request is in progress
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result without a request in progress");

endmodule

bind stereo_sample_ring_buffer_top ssrb_port_props u_ssrb_port_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== verif/ssrb_checker.sv =====
`timescale 1ns / 1ps
// Checker for the stereo sample ring buffer: watches the request, result and
// register channels, keeps its own ring model and compares every result.
// Depends on ssrb_pkg for the payload types, codes and clamp bounds.
module ssrb_checker #(
  parameter int RING_FRAMES = ssrb_pkg::RING_FRAMES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  ssrb_pkg::in_item_t          in_data,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  ssrb_pkg::out_item_t         out_data,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [ssrb_pkg::CFG_IW-1:0] cfg_index,
  input  logic [ssrb_pkg::CFG_DW-1:0] cfg_data,
  output int                          mismatches,
  output int                          replies_due
);
  import ssrb_pkg::*;

  localparam int MAX_PRINTS = 40;

  // Ring model: left sample in 31:16, right in 15:0
  logic [31:0] ring [RING_FRAMES];
  int unsigned wr_commit;
  int unsigned wr_pend;
  int unsigned rd_ptr;
  int unsigned blk_off;
  bit          blk_play;

  logic [1:0]  fmt;
  logic [14:0] ovf_limit;
  logic [12:0] blk_cfg;

  out_item_t   ring_replies [$];
  int          err_cnt = 0;

  assign mismatches = err_cnt;

  function automatic logic [15:0] sat_sample(input logic signed [31:0] s);
    if (s > CLAMP_HI) return CLAMP_HI[15:0];
    if (s < CLAMP_LO) return CLAMP_LO[15:0];
    return s[15:0];
  endfunction

  function automatic int unsigned ring_fill();
    return (wr_commit + RING_FRAMES - rd_ptr) % RING_FRAMES;
  endfunction

  function automatic logic [14:0] fill_report();
    int unsigned f;
    f = ring_fill();
    return (f > 32767) ? FILL_SAT : f[14:0];
  endfunction

  task automatic report_mismatch(input string what, input out_item_t got,
                                 input out_item_t want);
    if (err_cnt < MAX_PRINTS)
      $display("[%0t] %s: got %h want %h", $time, what, got, want);
    err_cnt++;
  endtask

  // Apply one accepted request to the model; queue its result if it has one.
  task automatic advance_ring(input in_item_t rq);
    logic [15:0] r16;
    logic [15:0] l16;
    logic [31:0] word;
    int unsigned bf;
    bit          drop;
    out_item_t   res;
    res = '0;
    if (rq.mode == MODE_PUSH) begin
      case (fmt)
        FMT_STEREO16: begin
          r16 = rq.sample_right[15:0];
          l16 = rq.sample_left[15:0];
        end
        FMT_MONO32: begin
          r16 = sat_sample(rq.sample_right);
          l16 = r16;
        end
        default: begin
          r16 = sat_sample(rq.sample_right);
          l16 = sat_sample(rq.sample_left);
        end
      endcase
      ring[wr_pend % RING_FRAMES] = {l16, r16};
      wr_pend = (wr_pend + 1) % RING_FRAMES;
      if (rq.batch_last) begin
        // commit test uses the fill level before the commit
        drop = !(ring_fill() < ovf_limit);
        if (drop) wr_pend = wr_commit;
        else wr_commit = wr_pend;
        res.kind = KIND_STATUS;
        res.batch_dropped = drop;
        res.fill_level = fill_report();
        ring_replies.push_back(res);
      end
    end else begin
      bf = (blk_cfg == 0) ? 1 : (blk_cfg > BLOCK_MAX) ? BLOCK_MAX : blk_cfg;
      if (blk_off == 0) blk_play = (ring_fill() >= bf);
      word = blk_play ? ring[(rd_ptr + blk_off) % RING_FRAMES] : '0;
      blk_off++;
      if (blk_off >= bf) begin
        if (blk_play) rd_ptr = (rd_ptr + bf) % RING_FRAMES;
        blk_off = 0;
      end
      res.kind = KIND_FRAME;
      res.out_right = word[15:0];
      res.out_left = word[31:16];
      res.underrun = !blk_play;
      res.fill_level = fill_report();
      ring_replies.push_back(res);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      foreach (ring[i]) ring[i] = '0;
      wr_commit = 0;
      wr_pend = 0;
      rd_ptr = 0;
      blk_off = 0;
      blk_play = 1'b0;
      fmt = FMT_RESET;
      ovf_limit = LIMIT_RESET;
      blk_cfg = BLOCK_RESET;
      ring_replies.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_INPUT_FORMAT:   fmt = cfg_data[1:0];
          CFG_OVERFLOW_LIMIT: ovf_limit = cfg_data;
          CFG_BLOCK_FRAMES:   blk_cfg = cfg_data[12:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (ring_replies.size() == 0) begin
          report_mismatch("result with nothing pending", out_data, '0);
        end else begin
          want = ring_replies.pop_front();
          if (out_data.kind !== want.kind)
            report_mismatch("kind", out_data, want);
          if (out_data.out_right !== want.out_right)
            report_mismatch("out_right", out_data, want);
          if (out_data.out_left !== want.out_left)
            report_mismatch("out_left", out_data, want);
          if (out_data.underrun !== want.underrun)
            report_mismatch("underrun", out_data, want);
          if (out_data.batch_dropped !== want.batch_dropped)
            report_mismatch("batch_dropped", out_data, want);
          if (out_data.fill_level !== want.fill_level)
            report_mismatch("fill_level", out_data, want);
        end
      end
      if (in_valid && in_ready) advance_ring(in_data);
    end
    replies_due <= ring_replies.size();
  end

endmodule

// ===== verif/stereo_sample_ring_buffer_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the stereo sample ring buffer: clock, reset, request and
// register stimulus, result backpressure and the verdict.
// Depends on ssrb_pkg, stereo_sample_ring_buffer_top and ssrb_checker.
module stereo_sample_ring_buffer_top_tb;
  import ssrb_pkg::*;

  localparam int          RING           = RING_FRAMES_DEF;
  // generous bound: ~900 requests plus stalls and gaps
  localparam int unsigned CYCLE_LIMIT    = 200000;
  // a push with no result is done in the cycle after its acceptance; wait well past that
  localparam int          SETTLE_CYCLES  = 8;
  localparam int          RANDOM_PHASES  = 6;
  localparam int          PHASE_REQUESTS = 140;
  localparam int          STEADY_PHASE   = 2;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_IW-1:0]   cfg_index = '0;
  logic [CFG_DW-1:0]   cfg_data  = '0;

  int                  mismatches;
  int                  replies_due;
  // no random idling on either side while set
  bit                  steady    = 1'b0;
  int unsigned         cycle_cnt = 0;

  stereo_sample_ring_buffer_top #(
    .RING_FRAMES(RING)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  ssrb_checker #(
    .RING_FRAMES(RING)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .replies_due(replies_due)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result side: ready drops in about 15 percent of cycles except in the steady phase.
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 15);
  end

  // Watchdog: a hang or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Mix of clamp edges, 16-bit range values and full 32-bit noise.
  function automatic logic [31:0] pick_sample();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'd32764 + $urandom_range(4);
      3: return 32'hFFFF_8000 + $urandom_range(4);
      4: return $urandom_range(65535) - 32768;
      default: return $urandom;
    endcase
  endfunction

  // One request: optional idle gap with valid low, then hold until accepted.
  task automatic send_request(input in_item_t rq);
    while (!steady && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= rq;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic push_frame(input logic [31:0] right, input logic [31:0] left,
                            input logic last);
    in_item_t rq;
    rq.mode = MODE_PUSH;
    rq.sample_right = right;
    rq.sample_left = left;
    rq.batch_last = last;
    send_request(rq);
  endtask

  // Sample fields and batch_last are don't-care on a pop; keep them random.
  task automatic pop_frame();
    in_item_t rq;
    rq.mode = MODE_POP;
    rq.sample_right = $urandom;
    rq.sample_left = $urandom;
    rq.batch_last = 1'($urandom);
    send_request(rq);
  endtask

  // Block idle: every result back, then time for a result-less push to finish.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (replies_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int          sent;
    int          run;
    int unsigned roll;
    logic [1:0]  fmt;
    logic [14:0] limit;
    logic [12:0] blk;
    in_item_t    junk;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---------------- directed part ----------------
    write_reg(CFG_INPUT_FORMAT, CFG_DW'(FMT_STEREO32));
    write_reg(CFG_OVERFLOW_LIMIT, 15'd4);
    write_reg(CFG_BLOCK_FRAMES, 15'd2);

    // pops on an empty ring: one silent block
    pop_frame();
    pop_frame();
    // 32-bit clamp at both ends, then commit with fill 0
    push_frame(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    push_frame(32'd32767, 32'hFFFF_8001, 1'b0);
    push_frame(32'hFFFF_8002, 32'd32766, 1'b1);
    // one played block, then a silent one (one frame left)
    pop_frame();
    pop_frame();
    pop_frame();
    pop_frame();

    // 16-bit raw format: low halves pass untouched
    drain();
    write_reg(CFG_INPUT_FORMAT, CFG_DW'(FMT_STEREO16));
    push_frame(32'h1234_8000, 32'hFFFF_7FFF, 1'b0);
    push_frame(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
    push_frame(pick_sample(), pick_sample(), 1'b1);
    // fill now at the limit: this batch is thrown away
    push_frame(pick_sample(), pick_sample(), 1'b1);

    // mono: right copied to left, left ignored
    drain();
    write_reg(CFG_INPUT_FORMAT, CFG_DW'(FMT_MONO32));
    push_frame(32'h4000_0000, 32'h0000_0001, 1'b1);
    pop_frame();
    pop_frame();
    push_frame(32'hFFFF_63C0, $urandom, 1'b1);

    // unused format code behaves as stereo 32-bit
    drain();
    write_reg(CFG_INPUT_FORMAT, 15'd3);
    push_frame(pick_sample(), pick_sample(), 1'b1);

    // zero limit: every batch dropped
    drain();
    write_reg(CFG_OVERFLOW_LIMIT, 15'd0);
    push_frame(pick_sample(), pick_sample(), 1'b1);

    // block size zero acts as one
    drain();
    write_reg(CFG_BLOCK_FRAMES, 15'd0);
    pop_frame();

    // all bits set: masked to 8191, capped at 4096; opens a silent block
    drain();
    write_reg(CFG_BLOCK_FRAMES, 15'h7FFF);
    pop_frame();
    // block size lowered mid-block: block closes on the next pop
    drain();
    write_reg(CFG_BLOCK_FRAMES, 15'd1);
    pop_frame();
    pop_frame();

    // upper extremes and a write to the unused register index
    drain();
    write_reg(CFG_OVERFLOW_LIMIT, 15'd32767);
    write_reg(CFG_BLOCK_FRAMES, 15'd4096);
    write_reg(2'd3, 15'($urandom));
    push_frame(pick_sample(), pick_sample(), 1'b1);
    pop_frame();

    // ---------------- random phases ----------------
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      fmt = 2'($urandom_range(3));
      case ($urandom_range(9))
        0: limit = 15'd0;
        1: limit = 15'd32767;
        default: limit = 15'($urandom_range(1, 48));
      endcase
      case ($urandom_range(9))
        0: blk = 13'd0;
        1: blk = 13'(4096 + $urandom_range(4095));
        default: blk = 13'($urandom_range(1, 8));
      endcase
      // don't-care upper bits of the data bus get random values
      write_reg(CFG_INPUT_FORMAT, {13'($urandom), fmt});
      write_reg(CFG_OVERFLOW_LIMIT, limit);
      write_reg(CFG_BLOCK_FRAMES, {2'($urandom), blk});
      steady <= (ph == STEADY_PHASE);

      sent = 0;
      while (sent < PHASE_REQUESTS) begin
        roll = $urandom_range(99);
        if (roll < 55) begin
          // well-formed batch, last push marked
          run = $urandom_range(1, 6);
          for (int k = 0; k < run; k++)
            push_frame(pick_sample(), pick_sample(), k == run - 1);
          sent += run;
        end else if (roll < 93) begin
          run = $urandom_range(1, 12);
          repeat (run) pop_frame();
          sent += run;
        end else begin
          // noise: any mode, any batch_last
          junk.mode = 1'($urandom);
          junk.sample_right = $urandom;
          junk.sample_left = $urandom;
          junk.batch_last = 1'($urandom);
          send_request(junk);
          sent++;
        end
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
